FILE: rtl/core/vtl_pkg.sv
// vtl_pkg: shared types and constants for the text line generator
// holds command and job codes, the register set and the queued job format
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vtl_pkg;

  // default geometry
  localparam int unsigned COLUMNS_DEF     = 20;
  localparam int unsigned ROWS_DEF        = 20;
  localparam int unsigned GLYPH_LINES_DEF = 24;
  localparam int unsigned FONT_CHARS_DEF  = 256;

  // field widths
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned BASE_W  = 10;
  localparam int unsigned HALF_W  = 4;
  localparam int unsigned PIX_W   = 8;

  // register reset values
  localparam logic [LINE_W-1:0] TOTAL_LINES_RST   = 10'd525;
  localparam logic [LINE_W-1:0] VSYNC_FIRST_RST   = 10'd10;
  localparam logic [LINE_W-1:0] VSYNC_LAST_RST    = 10'd11;
  localparam logic [LINE_W-1:0] VISIBLE_FIRST_RST = 10'd45;

  // queue and result buffer depths
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WR_CHAR = 2'd1,
    CMD_WR_FONT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_TICK    = 2'd0,
    JOB_WR_CHAR = 2'd1,
    JOB_WR_FONT = 2'd2
  } job_kind_e;

  typedef enum logic [1:0] {
    REG_TOTAL_LINES   = 2'd0,
    REG_VSYNC_FIRST   = 2'd1,
    REG_VSYNC_LAST    = 2'd2,
    REG_VISIBLE_FIRST = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [LINE_W-1:0] total_lines;
    logic [LINE_W-1:0] vsync_first;
    logic [LINE_W-1:0] vsync_last;
    logic [LINE_W-1:0] visible_first;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    logic              vsync;
    logic              visible;
    logic              row_ok;
    logic [BASE_W-1:0] char_base;
    logic [HALF_W-1:0] glyph_half;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic               vsync;
    logic               visible;
    logic [COUNT_W-1:0] column;
    logic [PIX_W-1:0]   pixels;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/vtl_front.sv
// vtl_front: accepts items, steps the line, row and glyph counters on ticks
// and turns each tick and each in-range store write into a job for the back end; uses vtl_pkg
`timescale 1ns / 1ps
`default_nettype none

module vtl_front import vtl_pkg::*; #(
  parameter int unsigned COLUMNS     = COLUMNS_DEF,
  parameter int unsigned ROWS        = ROWS_DEF,
  parameter int unsigned GLYPH_LINES = GLYPH_LINES_DEF,
  parameter int unsigned FONT_CHARS  = FONT_CHARS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              s_valid_i,
  input  wire logic [1:0]        s_cmd_i,
  input  wire logic [ADDR_W-1:0] s_addr_i,
  input  wire logic [DATA_W-1:0] s_data_i,
  output logic                   s_ready_o,
  input  wire logic              blocked_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output job_t                   q_job_o
);

  localparam int unsigned CHAR_DEPTH = ROWS * COLUMNS;
  localparam int unsigned FONT_DEPTH = FONT_CHARS * (GLYPH_LINES / 2);

  logic [LINE_W-1:0]  line_q, line_d;
  logic [COUNT_W-1:0] row_q, row_d;
  logic [COUNT_W-1:0] gl_q, gl_d;

  logic               accept;
  cmd_e               cmd;
  logic [LINE_W-1:0]  line_inc;
  logic               wrap;
  logic [COUNT_W-1:0] row_base, gl_base, gl_inc;
  logic               gl_wrap;
  logic               vs, vis;

  assign s_ready_o = !q_full_i && !blocked_i;
  assign accept    = s_valid_i && s_ready_o;
  assign cmd       = cmd_e'(s_cmd_i);

  always_comb begin
    line_inc = line_q + 1'b1;
    wrap     = (line_inc == cfg_i.total_lines);
    line_d   = wrap ? '0 : line_inc;
    row_base = wrap ? '0 : row_q;
    gl_base  = wrap ? '0 : gl_q;
    vs       = (line_d >= cfg_i.vsync_first) && (line_d <= cfg_i.vsync_last);
    vis      = (line_d >= cfg_i.visible_first);
    gl_inc   = gl_base + 1'b1;
    gl_wrap  = (gl_inc == COUNT_W'(GLYPH_LINES));
    gl_d     = vis ? (gl_wrap ? '0 : gl_inc) : gl_base;
    row_d    = (vis && gl_wrap) ? row_base + 1'b1 : row_base;
  end

  always_comb begin
    q_job_o.kind       = JOB_TICK;
    q_job_o.vsync      = vs;
    q_job_o.visible    = vis;
    q_job_o.row_ok     = (row_d < COUNT_W'(ROWS));
    q_job_o.char_base  = BASE_W'(row_d) * BASE_W'(COLUMNS);
    q_job_o.glyph_half = gl_d[COUNT_W-1:1];
    q_job_o.address    = s_addr_i;
    q_job_o.data       = s_data_i;
    q_push_o           = 1'b0;
    unique case (cmd)
      CMD_TICK: begin
        q_push_o = accept;
      end
      CMD_WR_CHAR: begin
        q_job_o.kind = JOB_WR_CHAR;
        q_push_o     = accept && (s_addr_i < ADDR_W'(CHAR_DEPTH));
      end
      CMD_WR_FONT: begin
        q_job_o.kind = JOB_WR_FONT;
        q_push_o     = accept && (s_addr_i < ADDR_W'(FONT_DEPTH));
      end
      CMD_UNUSED: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      row_q  <= '0;
      gl_q   <= '0;
    end else if (accept && cmd == CMD_TICK) begin
      line_q <= line_d;
      row_q  <= row_d;
      gl_q   <= gl_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vtl_queue.sv
// vtl_queue: short job queue between the front and back ends
// uses vtl_pkg for the job format
`timescale 1ns / 1ps
`default_nettype none

module vtl_queue import vtl_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vtl_back.sv
// vtl_back: executes jobs through a three stage pipe over the character
// and font stores and buffers results; uses vtl_pkg
`timescale 1ns / 1ps
`default_nettype none

module vtl_back import vtl_pkg::*; #(
  parameter int unsigned COLUMNS     = COLUMNS_DEF,
  parameter int unsigned ROWS        = ROWS_DEF,
  parameter int unsigned GLYPH_LINES = GLYPH_LINES_DEF,
  parameter int unsigned FONT_CHARS  = FONT_CHARS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  output logic      clearing_o,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  output res_t      m_res_o
);

  localparam int unsigned CHAR_DEPTH  = ROWS * COLUMNS;
  localparam int unsigned CHAR_AW     = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;
  localparam int unsigned FONT_STRIDE = GLYPH_LINES / 2;
  localparam int unsigned FONT_DEPTH  = FONT_CHARS * FONT_STRIDE;
  localparam int unsigned FONT_AW     = $clog2(FONT_DEPTH);
  localparam int unsigned OUT_PW      = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW      = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    job_kind_e          kind;
    logic               vsync;
    logic               visible;
    logic               row_ok;
    logic [COUNT_W-1:0] column;
    logic               last;
    logic [HALF_W-1:0]  glyph_half;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  data;
  } stage1_t;

  typedef struct packed {
    logic               vsync;
    logic               visible;
    logic [COUNT_W-1:0] column;
    logic               last;
    logic               font_ok;
  } stage2_t;

  logic [DATA_W-1:0] char_mem [CHAR_DEPTH];
  logic [DATA_W-1:0] font_mem [FONT_DEPTH];

  // clear sweep over the character store
  logic               clearing_q, clearing_d;
  logic [CHAR_AW-1:0] clr_addr_q, clr_addr_d;

  // issue stage
  logic [COUNT_W-1:0] col_q, col_d;
  logic [OUT_CW:0]    inflight;
  logic               credit_ok, issue, multi, col_last, char_rd;
  logic [BASE_W-1:0]  char_sum;
  logic [DATA_W-1:0]  char_rd_q;

  // font stage
  logic               p1_valid_q;
  stage1_t            p1_q;
  logic [DATA_W-1:0]  code;
  logic               font_ok;
  logic [ADDR_W-1:0]  font_sum;
  logic [DATA_W-1:0]  font_rd_q;

  // result stage
  logic               p2_valid_q;
  stage2_t            p2_q;
  res_t               res;

  // result buffer
  res_t               out_mem [OUT_DEPTH];
  logic [OUT_PW-1:0]  out_wr_q, out_rd_q;
  logic [OUT_CW-1:0]  out_cnt_q;
  logic               out_pop;

  assign clearing_o = clearing_q;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if (clr_addr_q == CHAR_AW'(CHAR_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    inflight  = (OUT_CW + 1)'(out_cnt_q) + (OUT_CW + 1)'(p1_valid_q)
              + (OUT_CW + 1)'(p2_valid_q);
    credit_ok = (inflight < (OUT_CW + 1)'(OUT_DEPTH));
    issue     = job_valid_i && !clearing_q && credit_ok;
    multi     = (job_i.kind == JOB_TICK) && job_i.visible;
    col_last  = !multi || (col_q == COUNT_W'(COLUMNS - 1));
    job_pop_o = issue && col_last;
    col_d     = issue ? (col_last ? '0 : col_q + 1'b1) : col_q;
    char_rd   = multi && job_i.row_ok;
    char_sum  = job_i.char_base + BASE_W'(col_q);
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      char_mem[clr_addr_q] <= '0;
    end else if (issue && job_i.kind == JOB_WR_CHAR) begin
      char_mem[job_i.address[CHAR_AW-1:0]] <= job_i.data;
    end else if (issue && char_rd) begin
      char_rd_q <= char_mem[char_sum[CHAR_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_q.kind       <= job_i.kind;
      p1_q.vsync      <= job_i.vsync;
      p1_q.visible    <= job_i.visible;
      p1_q.row_ok     <= job_i.row_ok;
      p1_q.column     <= col_q;
      p1_q.last       <= col_last;
      p1_q.glyph_half <= job_i.glyph_half;
      p1_q.address    <= job_i.address;
      p1_q.data       <= job_i.data;
    end
  end

  // rows past the screen read character zero
  always_comb begin
    code     = (p1_q.kind == JOB_TICK && p1_q.visible && p1_q.row_ok) ? char_rd_q : '0;
    font_ok  = ({1'b0, code} < (DATA_W + 1)'(FONT_CHARS));
    font_sum = ADDR_W'(code) * ADDR_W'(FONT_STRIDE) + ADDR_W'(p1_q.glyph_half);
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q && p1_q.kind == JOB_WR_FONT) begin
      font_mem[p1_q.address[FONT_AW-1:0]] <= p1_q.data;
    end else if (p1_valid_q && p1_q.kind == JOB_TICK && p1_q.visible && font_ok) begin
      font_rd_q <= font_mem[font_sum[FONT_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      p2_q.vsync   <= p1_q.vsync;
      p2_q.visible <= p1_q.visible;
      p2_q.column  <= p1_q.column;
      p2_q.last    <= p1_q.last;
      p2_q.font_ok <= font_ok;
    end
  end

  always_comb begin
    res.vsync   = p2_q.vsync;
    res.visible = p2_q.visible;
    res.column  = p2_q.column;
    res.pixels  = (p2_q.visible && p2_q.font_ok) ? font_rd_q : '0;
    res.last    = p2_q.last;
  end

  assign m_valid_o = (out_cnt_q != '0);
  assign m_res_o   = out_mem[out_rd_q];
  assign out_pop   = m_valid_o && m_ready_i;

  always_ff @(posedge clk_i) begin
    if (p2_valid_q) begin
      out_mem[out_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      out_wr_q   <= '0;
      out_rd_q   <= '0;
      out_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      col_q      <= col_d;
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q && (p1_q.kind == JOB_TICK);
      if (p2_valid_q) begin
        out_wr_q <= (out_wr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= (out_rd_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
      end
      if (p2_valid_q && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_pop && !p2_valid_q) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vga_text_line_generator_top.sv
// vga_text_line_generator_top: text-mode line generator, register port and wiring
// throughput: a visible tick yields COLUMNS font bytes, one a cycle while the result buffer
//   has room (character store read then font store read); hidden ticks and writes are single jobs
// reset: registers to 525/10/11/45, counters zero, then a sweep over the ROWS*COLUMNS cells
//   (400 at default size) clears the character store while s_axis_tready_o stays low
`timescale 1ns / 1ps
`default_nettype none

module vga_text_line_generator_top import vtl_pkg::*; #(
  parameter int unsigned COLUMNS     = COLUMNS_DEF,
  parameter int unsigned ROWS        = ROWS_DEF,
  parameter int unsigned GLYPH_LINES = GLYPH_LINES_DEF,
  parameter int unsigned FONT_CHARS  = FONT_CHARS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // address[11:0], data[19:12], zero pad
  input  wire logic [1:0]  s_axis_tuser_i,  // command[1:0]
  // result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // vsync_active[0], column[5:1], pixels[13:6], zero pad
  output logic             m_axis_tuser_o,  // visible
  output logic             m_axis_tlast_o,  // last
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic     q_push, q_full, q_valid, q_pop;
  job_t     q_job_in, q_job_out;
  logic     clearing;
  res_t     res;

  // register port: always ready, word addressed
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_TOTAL_LINES:   prdata = 32'(cfg_q.total_lines);
      REG_VSYNC_FIRST:   prdata = 32'(cfg_q.vsync_first);
      REG_VSYNC_LAST:    prdata = 32'(cfg_q.vsync_last);
      REG_VISIBLE_FIRST: prdata = 32'(cfg_q.visible_first);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_lines   <= TOTAL_LINES_RST;
      cfg_q.vsync_first   <= VSYNC_FIRST_RST;
      cfg_q.vsync_last    <= VSYNC_LAST_RST;
      cfg_q.visible_first <= VISIBLE_FIRST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TOTAL_LINES:   cfg_q.total_lines   <= pwdata[LINE_W-1:0];
        REG_VSYNC_FIRST:   cfg_q.vsync_first   <= pwdata[LINE_W-1:0];
        REG_VSYNC_LAST:    cfg_q.vsync_last    <= pwdata[LINE_W-1:0];
        REG_VISIBLE_FIRST: cfg_q.visible_first <= pwdata[LINE_W-1:0];
      endcase
    end
  end

  // front end: line bookkeeping happens here, in item order, so the back end
  // only sees ready-made jobs and can run behind without affecting the counters
  vtl_front #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .GLYPH_LINES (GLYPH_LINES),
    .FONT_CHARS  (FONT_CHARS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid_i),
    .s_cmd_i   (s_axis_tuser_i),
    .s_addr_i  (s_axis_tdata_i[ADDR_W-1:0]),
    .s_data_i  (s_axis_tdata_i[ADDR_W +: DATA_W]),
    .s_ready_o (s_axis_tready_o),
    .blocked_i (clearing),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (q_job_in)
  );

  // decouples item acceptance from the per-column work of a visible line
  vtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job_out)
  );

  // back end: store writes and reads stay in job order, so a write is seen by
  // every later tick and by no earlier one
  vtl_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .GLYPH_LINES (GLYPH_LINES),
    .FONT_CHARS  (FONT_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job_out),
    .job_pop_o   (q_pop),
    .clearing_o  (clearing),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (res)
  );

  // result packing
  assign m_axis_tdata_o = {2'b00, res.pixels, res.column, res.vsync};
  assign m_axis_tuser_o = res.visible;
  assign m_axis_tlast_o = res.last;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// testbench for vga_text_line_generator_top: line ticks and store writes go in on the
// input stream, font bytes are predicted in step and checked on the result stream
// depends on vtl_pkg and the rtl of vga_text_line_generator_top
`timescale 1ns / 1ps

module testbench import vtl_pkg::*;;

  // geometry of the instance, the package defaults
  localparam int unsigned COLUMNS     = COLUMNS_DEF;
  localparam int unsigned ROWS        = ROWS_DEF;
  localparam int unsigned GLYPH_LINES = GLYPH_LINES_DEF;
  localparam int unsigned FONT_CHARS  = FONT_CHARS_DEF;
  localparam int unsigned CHAR_CELLS  = ROWS * COLUMNS;
  localparam int unsigned FONT_STRIDE = GLYPH_LINES / 2;
  localparam int unsigned FONT_CELLS  = FONT_CHARS * FONT_STRIDE;

  // run control
  localparam int unsigned SETTLE_CYCLES = 32;        // writes still in flight after the last result
  localparam int unsigned HOLD_CYCLES   = 800;       // long result hold-off
  localparam int unsigned RANDOM_ITEMS  = 22;        // per random phase
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int unsigned LIMIT_NS      = 2_000_000; // run time limit in ns

  typedef struct {
    cmd_e       cmd;
    logic [11:0] addr;
    logic [7:0]  value;
  } video_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // address[11:0], data[19:12], zero pad
  logic [1:0]  s_axis_tuser_i = CMD_TICK;  // command[1:0]

  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // vsync_active[0], column[5:1], pixels[13:6], zero pad
  logic        m_axis_tuser_o;        // visible
  logic        m_axis_tlast_o;        // last

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vga_text_line_generator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // ---------------------------------------------------------------------------
  // shadow of the generator: registers, counters and both stores
  // ---------------------------------------------------------------------------
  logic [LINE_W-1:0]  cfg_total;
  logic [LINE_W-1:0]  cfg_vs_first;
  logic [LINE_W-1:0]  cfg_vs_last;
  logic [LINE_W-1:0]  cfg_visible;
  logic [LINE_W-1:0]  line_q;
  logic [COUNT_W-1:0] row_q;
  logic [COUNT_W-1:0] glyph_q;
  logic [7:0]         char_mem [CHAR_CELLS];
  logic [7:0]         font_mem [FONT_CELLS];   // left unknown until written

  video_cmd_t video_cmds_q[$];     // items waiting for the driver
  res_t       line_beats_due[$];   // font bytes and hidden-line markers still to come

  // character codes whose whole glyph has been written, the only codes put in the store
  logic [7:0] glyph_codes [6];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned visible_lines = 0;
  int unsigned overrun_lines = 0;   // visible lines on rows past the screen

  // works out what one accepted item does to the generator and which beats it yields
  task automatic compute_line_beats(input cmd_e cmd, input logic [11:0] addr,
                                    input logic [7:0] value);
    res_t       beat;
    logic [7:0] code;
    int         font_idx;
    case (cmd)
      CMD_WR_CHAR: begin
        if (addr < CHAR_CELLS) char_mem[addr] = value;
      end
      CMD_WR_FONT: begin
        if (addr < FONT_CELLS) font_mem[addr] = value;
      end
      CMD_TICK: begin
        line_q = line_q + 10'd1;
        // clear only on an exact match, a lowered total lets the count run to the wrap
        if (line_q == cfg_total) begin
          line_q  = '0;
          row_q   = '0;
          glyph_q = '0;
        end
        beat = '0;
        beat.vsync = (line_q >= cfg_vs_first) && (line_q <= cfg_vs_last);
        if (line_q < cfg_visible) begin
          beat.last = 1'b1;
          line_beats_due.push_back(beat);
        end else begin
          glyph_q = glyph_q + 5'd1;
          if (glyph_q == GLYPH_LINES) begin
            row_q   = row_q + 5'd1;
            glyph_q = '0;
          end
          visible_lines++;
          if (row_q >= ROWS) overrun_lines++;
          beat.visible = 1'b1;
          for (int c = 0; c < COLUMNS; c++) begin
            // rows past the screen read character zero
            code = (row_q < ROWS) ? char_mem[row_q * COLUMNS + c] : 8'd0;
            font_idx = code * FONT_STRIDE + glyph_q / 2;
            beat.column = 5'(c);
            beat.pixels = font_mem[font_idx];
            beat.last   = (c == COLUMNS - 1);
            line_beats_due.push_back(beat);
          end
        end
      end
      default: begin
        // unused command, nothing happens
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued items, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver_blk
    video_cmd_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        compute_line_beats(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[11:0],
                           s_axis_tdata_i[19:12]);
        cmds_sent++;
      end
      // slot free: either nothing offered or the offered item just went in
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (video_cmds_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = video_cmds_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'b0, nxt.value, nxt.addr};
          s_axis_tuser_i  <= nxt.cmd;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off whenever hold_req toggles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack        <= hold_req;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor_blk
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (line_beats_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result item with nothing expected, expected none, got %h",
                   $time, m_axis_tdata_o);
      end else begin
        want = line_beats_due.pop_front();
        beats_checked++;
        check_field("vsync_active", want.vsync,   m_axis_tdata_o[0]);
        check_field("visible",      want.visible, m_axis_tuser_o);
        check_field("column",       want.column,  m_axis_tdata_o[5:1]);
        check_field("pixels",       want.pixels,  m_axis_tdata_o[13:6]);
        check_field("last",         want.last,    m_axis_tlast_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input cmd_e cmd, input logic [11:0] addr, input logic [7:0] value);
    video_cmd_t it;
    it.cmd   = cmd;
    it.addr  = addr;
    it.value = value;
    video_cmds_q.push_back(it);
  endtask

  task automatic queue_ticks(input int unsigned count);
    repeat (count) queue_item(CMD_TICK, 12'($urandom_range(4095)), 8'($urandom_range(255)));
  endtask

  // mostly ticks and character writes with ready codes, some font rewrites and noise
  task automatic queue_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      queue_ticks(1);
    else if (pick < 72)
      queue_item(CMD_WR_CHAR,
                 ($urandom_range(9) == 0) ? 12'($urandom_range(4095, CHAR_CELLS))
                                          : 12'($urandom_range(CHAR_CELLS - 1)),
                 glyph_codes[$urandom_range(5)]);
    else if (pick < 94)
      queue_item(CMD_WR_FONT, 12'($urandom_range(4095)), 8'($urandom_range(255)));
    else
      queue_item(CMD_UNUSED, 12'($urandom_range(4095)), 8'($urandom_range(255)));
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [LINE_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TOTAL_LINES:   cfg_total    = value;
      REG_VSYNC_FIRST:   cfg_vs_first = value;
      REG_VSYNC_LAST:    cfg_vs_last  = value;
      REG_VISIBLE_FIRST: cfg_visible  = value;
      default: ;
    endcase
  endtask

  task automatic set_timing(input int unsigned total, input int unsigned vs_first,
                            input int unsigned vs_last, input int unsigned visible);
    write_reg(REG_TOTAL_LINES,   LINE_W'(total));
    write_reg(REG_VSYNC_FIRST,   LINE_W'(vs_first));
    write_reg(REG_VSYNC_LAST,    LINE_W'(vs_last));
    write_reg(REG_VISIBLE_FIRST, LINE_W'(visible));
  endtask

  // sender waits until all is in and every expected beat has come out
  task automatic drain_all();
    do @(negedge clk_i);
    while (video_cmds_q.size() != 0 || s_axis_tvalid_i || line_beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin : sequence_blk
    int unsigned top;
    int unsigned vis;
    cfg_total    = TOTAL_LINES_RST;
    cfg_vs_first = VSYNC_FIRST_RST;
    cfg_vs_last  = VSYNC_LAST_RST;
    cfg_visible  = VISIBLE_FIRST_RST;
    line_q  = '0;
    row_q   = '0;
    glyph_q = '0;
    foreach (char_mem[i]) char_mem[i] = 8'd0;
    glyph_codes[0] = 8'h00;
    glyph_codes[1] = 8'hff;
    glyph_codes[2] = 8'h55;
    glyph_codes[3] = 8'haa;
    glyph_codes[4] = 8'($urandom_range(1, 84));
    glyph_codes[5] = 8'($urandom_range(86, 169));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset timing, no idling: fill the glyphs of every code that will be shown
    foreach (glyph_codes[k])
      for (int g = 0; g < FONT_STRIDE; g++)
        queue_item(CMD_WR_FONT, 12'(glyph_codes[k] * FONT_STRIDE + g),
                   8'($urandom_range(255)));
    // store edges, ignored addresses and the unused command
    queue_item(CMD_WR_CHAR, 12'd0,                 8'hff);
    queue_item(CMD_WR_CHAR, 12'(COLUMNS - 1),      8'h55);
    queue_item(CMD_WR_CHAR, 12'(COLUMNS),          8'haa);
    queue_item(CMD_WR_CHAR, 12'(CHAR_CELLS - 1),   8'hff);
    queue_item(CMD_WR_CHAR, 12'(CHAR_CELLS),       8'haa);
    queue_item(CMD_WR_CHAR, 12'hfff,               8'h55);
    queue_item(CMD_WR_FONT, 12'(FONT_CELLS),       8'h00);
    queue_item(CMD_WR_FONT, 12'hfff,               8'hff);
    queue_item(CMD_UNUSED,  12'hfff,               8'hff);
    queue_item(CMD_UNUSED,  12'h000,               8'h00);
    // hidden lines across the default sync window
    queue_ticks(12);
    drain_all();

    // long frame, sync everywhere: visible lines across a row step while the
    // receiver holds off long enough for the block to back up onto its input
    set_timing(1023, 0, 1023, 13);
    queue_ticks(40);
    hold_req = ~hold_req;
    drain_all();

    // total lowered below the current line: the count runs on without clearing,
    // every line hidden and sync only on the last line of the count
    set_timing(2, 1023, 1023, 1000);
    queue_ticks(8);
    drain_all();

    // random phases with the idling pattern changing from one to the next
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // empty sync window, every line visible
          set_timing(2, 1, 0, 0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_timing(60, 5, 9, 20);
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        default: begin
          top = $urandom_range(line_q + 120, line_q + 2);
          vis = $urandom_range(top);
          set_timing(top, $urandom_range(top), $urandom_range(top), vis);
          send_idle_pct  = (ph == 2) ? 0 : 32;
          recv_stall_pct = (ph == 2) ? 74 : 32;
        end
      endcase
      repeat (RANDOM_ITEMS) queue_random_item();
      drain_all();
    end

    $display("sent %0d items, checked %0d result items, %0d visible lines (%0d past the screen)",
             cmds_sent, beats_checked, visible_lines, overrun_lines);
    $display("covered store edges, a row step under a long hold-off, a lowered total,",
             " four random phases with idling and stalls");
    if (errors == 0 && line_beats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // overall time limit
  // ---------------------------------------------------------------------------
  initial begin
    #LIMIT_NS;
    $display("timeout with %0d result items still expected", line_beats_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vtl_pkg.sv
rtl/core/vtl_front.sv
rtl/core/vtl_queue.sv
rtl/core/vtl_back.sv
rtl/core/vga_text_line_generator_top.sv
verif/testbench.sv
